/* design/tas_pkg.sv */
// Package for the transaction amount sorter: field widths, word types,
// action codes, controller states and the controller/datapath command bundles.
// No dependencies.
`default_nettype none

package tas_pkg;

    localparam int AMT_W  = 40;
    localparam int TIME_W = 32;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef struct packed {
        logic                     action;
        logic signed [AMT_W-1:0]  amount;
        logic        [TIME_W-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic        [TIME_W-1:0] timestamp_res;
        logic signed [AMT_W-1:0]  amount_res;
        logic                     last;
    } t_out_item;

    // One stored log or sort entry.
    typedef struct packed {
        logic signed [AMT_W-1:0]  amount;
        logic        [TIME_W-1:0] timestamp;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_POS,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B,
        S_EMIT_RD,
        S_EMIT_SHOW
    } t_state;

    typedef struct packed {
        logic append;     // write input word at the log tail
        logic idx_clr;    // clear scan index and sort position
        logic copy_step;  // read next log entry into the sort buffer
        logic pos_start;  // read sort[pos], set scan to pos + 1
        logic scan_step;  // read next sort entry for the minimum search
        logic wr_min;     // write the minimum into sort[pos]
        logic wr_posent;  // write the old sort[pos] into sort[pick]
        logic pos_inc;    // advance sort position
        logic scan_clr;   // clear scan index before emitting
        logic emit_rd;    // read sort[scan] for output
        logic emit_inc;   // advance output index
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic copy_done;
        logic scan_done;
        logic sort_done;
        logic swap_need;
        logic emit_last;
    } t_dp_status;

endpackage

`default_nettype wire

/* design/tas_stream_if.sv */
// Valid/ready stream channel carrying one word of payload type T.
// No dependencies.
`default_nettype none

interface tas_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

/* design/tas_datapath.sv */
// Datapath of the transaction amount sorter: log and sort memories, indexes,
// minimum search registers. Depends on tas_pkg.
`default_nettype none

module tas_datapath #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  tas_pkg::t_dp_cmd       i_cmd,
    output tas_pkg::t_dp_status    o_status,
    input  tas_pkg::t_in_item      i_in_item,
    output tas_pkg::t_out_item     o_out_item
);
    import tas_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_entry r_log_mem  [MAX_ENTRIES];
    t_entry r_sort_mem [MAX_ENTRIES];

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_scan;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] r_pick;
    t_entry        r_min;
    t_entry        r_pos_ent;

    t_entry        r_log_rd;
    logic          r_lrd_vld;
    logic [AW-1:0] r_lrd_idx;

    t_entry        r_sort_rd;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;

    logic          full;
    logic          scan_live;
    logic          log_rd_en;
    logic          sort_rd_en;
    logic [AW-1:0] sort_rd_addr;

    assign full      = (r_count == CW'(MAX_ENTRIES));
    assign scan_live = (r_scan < r_count);
    assign log_rd_en = i_cmd.copy_step && scan_live;

    always_comb begin
        sort_rd_en   = 1'b0;
        sort_rd_addr = r_scan[AW-1:0];
        if (i_cmd.pos_start) begin
            sort_rd_en   = 1'b1;
            sort_rd_addr = r_pos;
        end else if (i_cmd.scan_step && scan_live) begin
            sort_rd_en = 1'b1;
        end else if (i_cmd.emit_rd) begin
            sort_rd_en = 1'b1;
        end
    end

    // Log memory: append at the tail, read during the copy.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            r_log_mem[r_count[AW-1:0]] <= '{amount: i_in_item.amount,
                                            timestamp: i_in_item.timestamp};
        end
        if (log_rd_en) begin
            r_log_rd <= r_log_mem[r_scan[AW-1:0]];
        end
    end

    // Sort memory: one write port shared by copy and swap, one read port.
    always_ff @(posedge i_clk) begin
        if (r_lrd_vld) begin
            r_sort_mem[r_lrd_idx] <= r_log_rd;
        end else if (i_cmd.wr_min) begin
            r_sort_mem[r_pos] <= r_min;
        end else if (i_cmd.wr_posent) begin
            r_sort_mem[r_pick] <= r_pos_ent;
        end
        if (sort_rd_en) begin
            r_sort_rd <= r_sort_mem[sort_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_lrd_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cmd.append && !full) begin
                r_count <= r_count + CW'(1);
            end
            r_lrd_vld <= log_rd_en;
            r_rd_vld  <= sort_rd_en;
        end
    end

    // Indexes and minimum search.
    always_ff @(posedge i_clk) begin
        r_lrd_idx <= r_scan[AW-1:0];
        r_rd_idx  <= sort_rd_addr;

        if (i_cmd.idx_clr || i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.pos_start) begin
            r_scan <= CW'(r_pos) + CW'(1);
        end else if ((i_cmd.copy_step || i_cmd.scan_step) && scan_live) begin
            r_scan <= r_scan + CW'(1);
        end else if (i_cmd.emit_inc) begin
            r_scan <= r_scan + CW'(1);
        end

        if (i_cmd.idx_clr) begin
            r_pos <= '0;
        end else if (i_cmd.pos_inc) begin
            r_pos <= r_pos + AW'(1);
        end

        if (r_rd_vld) begin
            if (r_rd_idx == r_pos) begin
                r_min     <= r_sort_rd;
                r_pos_ent <= r_sort_rd;
                r_pick    <= r_pos;
            end else if (r_sort_rd.amount < r_min.amount) begin
                r_min  <= r_sort_rd;
                r_pick <= r_rd_idx;
            end
        end
    end

    assign o_status.empty     = (r_count == '0);
    assign o_status.copy_done = !scan_live && !r_lrd_vld;
    assign o_status.scan_done = !scan_live && !r_rd_vld;
    assign o_status.sort_done = ((CW'(r_pos) + CW'(1)) >= r_count);
    assign o_status.swap_need = (r_pick != r_pos);
    assign o_status.emit_last = ((r_scan + CW'(1)) == r_count);

    assign o_out_item.timestamp_res = r_sort_rd.timestamp;
    assign o_out_item.amount_res    = r_sort_rd.amount;
    assign o_out_item.last          = o_status.emit_last;

endmodule

`default_nettype wire

/* design/tas_controller.sv */
// Controller of the transaction amount sorter: sequences append, copy,
// selection sort and emit phases. Depends on tas_pkg.
`default_nettype none

module tas_controller (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire                    i_in_action,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output tas_pkg::t_dp_cmd       o_cmd,
    input  tas_pkg::t_dp_status    i_status
);
    import tas_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_action == ACT_APPEND) begin
                        o_cmd.append = 1'b1;
                    end else if (!i_status.empty) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_COPY;
                    end
                end
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_status.copy_done) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                if (i_status.sort_done) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_EMIT_RD;
                end else begin
                    o_cmd.pos_start = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_SWAP_A;
                end
            end
            S_SWAP_A: begin
                if (i_status.swap_need) begin
                    o_cmd.wr_min = 1'b1;
                    n_state      = S_SWAP_B;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                    n_state       = S_POS;
                end
            end
            S_SWAP_B: begin
                o_cmd.wr_posent = 1'b1;
                o_cmd.pos_inc   = 1'b1;
                n_state         = S_POS;
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EMIT_SHOW;
            end
            S_EMIT_SHOW: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_inc = 1'b1;
                        n_state        = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/transaction_amount_sorter.sv */
// Transaction amount sorter, top level. Uses tas_pkg, tas_stream_if,
// tas_controller and tas_datapath.
// A report on N entries copies the log into the sort buffer, runs a selection
//   sort with a swap only for positions that need one, then emits the N
//   words in order, each held through any output stall.
// Throughput: one input word at a time; set by the single read port of the
//   sort memory, which delivers one compare per cycle.
// Reset: clears the entry count and the controller; memories are not cleared.
`default_nettype none

module transaction_amount_sorter #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tas_stream_if.sink  i_in,
    tas_stream_if.source o_out
);
    import tas_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    t_out_item  out_item;

    // Controller: accepts words only when idle; a report on a non-empty log walks copy, sort, emit.
    tas_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.data.action),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Datapath: log memory in arrival order, sort buffer, minimum search.
    tas_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_item  (i_in.data),
        .o_out_item (out_item)
    );

    // Output word is held in the sort read register until taken.
    assign o_out.data = out_item;

endmodule

`default_nettype wire

/* sim/tas_sort_checker.sv */
// Checker for the transaction amount sorter: keeps its own copy of the log,
// predicts the sorted report words and compares every output word.
// Uses tas_pkg and tas_stream_if.
`default_nettype none

module tas_sort_checker
    import tas_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    tas_stream_if i_in,
    tas_stream_if i_out,
    output int    o_fail_count,
    output int    o_pending
);

    t_entry    log_mem  [MAX_ENTRIES];
    t_entry    sort_mem [MAX_ENTRIES];
    int        log_len;
    int        fails;
    t_out_item sorted_q [$];

    // Copy the log, order the copy by amount with selection sort and queue
    // one word per entry.
    function automatic void predict_sorted_report();
        int        pos;
        int        scan;
        int        pick;
        t_entry    held;
        t_out_item word;
        for (pos = 0; pos < log_len; pos++) begin
            sort_mem[pos] = log_mem[pos];
        end
        for (pos = 0; pos + 1 < log_len; pos++) begin
            pick = pos;
            for (scan = pos + 1; scan < log_len; scan++) begin
                if ($signed(sort_mem[scan].amount) < $signed(sort_mem[pick].amount)) begin
                    pick = scan;
                end
            end
            if (pick != pos) begin
                held           = sort_mem[pos];
                sort_mem[pos]  = sort_mem[pick];
                sort_mem[pick] = held;
            end
        end
        for (pos = 0; pos < log_len; pos++) begin
            word.timestamp_res = sort_mem[pos].timestamp;
            word.amount_res    = sort_mem[pos].amount;
            word.last          = (pos + 1 == log_len);
            sorted_q.push_back(word);
        end
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            log_len = 0;
            fails   = 0;
            sorted_q.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (i_in.data.action == ACT_APPEND) begin
                    if (log_len < MAX_ENTRIES) begin
                        log_mem[log_len].amount    = i_in.data.amount;
                        log_mem[log_len].timestamp = i_in.data.timestamp;
                        log_len++;
                    end
                end else begin
                    predict_sorted_report();
                end
            end
            if (i_out.valid && i_out.ready) begin
                got = i_out.data;
                if (sorted_q.size() == 0) begin
                    fails++;
                    $display("%0t: output word with none expected, expected nothing got ts %0d amount %0d last %0b",
                             $time, got.timestamp_res, $signed(got.amount_res), got.last);
                end else begin
                    want = sorted_q.pop_front();
                    check_field("timestamp_res", longint'(want.timestamp_res),
                                longint'(got.timestamp_res));
                    check_field("amount_res", longint'($signed(want.amount_res)),
                                longint'($signed(got.amount_res)));
                    check_field("last", longint'(want.last), longint'(got.last));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= sorted_q.size();
    end

endmodule

`default_nettype wire

/* sim/tb_transaction_amount_sorter.sv */
// Testbench top for the transaction amount sorter: clock, reset, stimulus,
// output stalls, watchdog and verdict. Uses tas_pkg, tas_stream_if,
// transaction_amount_sorter and tas_sort_checker.
`default_nettype none

module tb_transaction_amount_sorter
    import tas_pkg::*;
;

    localparam int MAX_ENTRIES    = 64;
    // Words that change the block's state; appends dropped on a full log
    // do not count.
    localparam int RANDOM_WORDS   = 135;
    // Final stretch of the run with no idling on either side.
    localparam int CALM_TAIL      = 20;
    // A full 64-entry report sorts without moving a word, so the limit must cover the whole sort.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;

    localparam logic signed [AMT_W-1:0] AMT_MAX = {1'b0, {(AMT_W-1){1'b1}}};
    localparam logic signed [AMT_W-1:0] AMT_MIN = {1'b1, {(AMT_W-1){1'b0}}};

    logic clk;
    logic rst_n;
    bit   quiet;         // suppress idling on both sides
    int   logged;        // entries the log holds, for shaping the stimulus
    int   idle_cycles;
    int   fail_count;
    int   pending_words;

    tas_stream_if #(.T(t_in_item))  in_ch  ();
    tas_stream_if #(.T(t_out_item)) out_ch ();

    transaction_amount_sorter #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tas_sort_checker #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) sort_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drop ready in random bursts; start no new burst while quiet.
    initial begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 15) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    // End the run when no word moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one input word, after an optional random gap, and hold it until
    // the block takes it. Called right after a rising edge.
    task automatic send_word(input logic act, input logic signed [AMT_W-1:0] amt,
                             input logic [TIME_W-1:0] stamp);
        t_in_item word;
        int       gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word.action    = act;
        word.amount    = amt;
        word.timestamp = stamp;
        in_ch.valid <= 1'b1;
        in_ch.data  <= word;
        do @(posedge clk); while (!in_ch.ready);
        if (act == ACT_APPEND && logged < MAX_ENTRIES) begin
            logged++;
        end
    endtask

    // Mix full-range amounts with a small pool of repeated values, so that
    // ties are common, and with the extremes.
    function automatic logic signed [AMT_W-1:0] pick_amount();
        logic signed [AMT_W-1:0] amt;
        logic [63:0]             raw;
        int                      tie;
        raw = {$urandom, $urandom};
        amt = raw[AMT_W-1:0];
        tie = int'($urandom_range(0, 4)) - 2;
        case ($urandom_range(0, 5))
            0, 1: begin
                amt = AMT_W'(tie * 250);
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: amt = AMT_MAX;
                    1: amt = AMT_MIN;
                    2: amt = 0;
                    3: amt = -1;
                    default: amt = 1;
                endcase
            end
            default: ;
        endcase
        return amt;
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        logic [TIME_W-1:0] stamp;
        stamp = $urandom;
        case ($urandom_range(0, 7))
            0: stamp = '0;
            1: stamp = '1;
            default: ;
        endcase
        return stamp;
    endfunction

    initial begin
        int  useful;
        int  sent;
        bit  full;
        logic act;
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        quiet  = 1'b0;
        logged = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: report on an empty log, a single-entry report,
        // the amount extremes, ties (also at the minimum) and two reports
        // back to back to show the log keeps its arrival order.
        send_word(ACT_REPORT, 0, 0);
        send_word(ACT_APPEND, AMT_MAX, 32'h0000_0000);
        send_word(ACT_REPORT, AMT_MIN, 32'hFFFF_FFFF);
        send_word(ACT_APPEND, AMT_MIN, 32'hFFFF_FFFF);
        send_word(ACT_APPEND, 0, 32'd1);
        send_word(ACT_APPEND, -1, 32'h8000_0000);
        send_word(ACT_APPEND, 1, 32'h7FFF_FFFF);
        send_word(ACT_APPEND, 100, 32'd10);
        send_word(ACT_APPEND, 100, 32'd11);
        send_word(ACT_APPEND, -1, 32'd12);
        send_word(ACT_APPEND, 100, 32'd13);
        send_word(ACT_APPEND, AMT_MIN, 32'd14);
        send_word(ACT_APPEND, 40'sh55_5555_5555, 32'hAAAA_AAAA);
        send_word(ACT_APPEND, 40'shAA_AAAA_AAAA, 32'h5555_5555);
        send_word(ACT_REPORT, 0, 0);
        send_word(ACT_REPORT, 0, 0);

        // Random part: fill the log with reports of growing size in between,
        // then keep reporting the full log and throw in dropped appends.
        useful = 0;
        sent   = 0;
        while (useful < RANDOM_WORDS) begin
            if (sent % 16 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (useful >= RANDOM_WORDS - CALM_TAIL) begin
                quiet = 1'b1;
            end
            full = (logged >= MAX_ENTRIES);
            if (full) begin
                act = ($urandom_range(0, 9) < 8) ? ACT_REPORT : ACT_APPEND;
            end else begin
                act = ($urandom_range(0, 3) == 0) ? ACT_REPORT : ACT_APPEND;
            end
            if (!(full && act == ACT_APPEND)) begin
                useful++;
            end
            sent++;
            send_word(act, pick_amount(), pick_time());
        end
        in_ch.valid <= 1'b0;

        // Wait for every expected word, then let stray words show up.
        do @(posedge clk); while (pending_words != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* transaction_amount_sorter.f */
design/tas_pkg.sv
design/tas_stream_if.sv
design/tas_datapath.sv
design/tas_controller.sv
design/transaction_amount_sorter.sv
sim/tas_sort_checker.sv
sim/tb_transaction_amount_sorter.sv
